### hw/rtl/swcol_pkg.sv
// ---------------------------------------------------------------------------
// Stopwatch LED column package
// Shared types, font tables and layout tables for the stopwatch column block.
// ---------------------------------------------------------------------------
`default_nettype none

package swcol_pkg;

  localparam int DISPLAY_MODULES_DEF = 4;
  localparam int MAX_COLS            = 32;
  localparam int NUM_DIGITS          = 7;
  localparam int NUM_DIV_DIGITS      = 6;
  localparam int NUM_SYMS            = 7;
  localparam int REM_W               = 22;
  localparam int MULT_W              = 23;

  localparam logic [31:0] LIMIT_SEC  = 32'd60000;
  localparam logic [31:0] LIMIT_MIN1 = 32'd600000;
  localparam logic [31:0] LIMIT_HOUR = 32'd3600000;

  typedef enum logic [1:0] {
    FMT_SEC,
    FMT_MIN1,
    FMT_MIN2,
    FMT_OVER
  } fmt_t;

  typedef enum logic [3:0] {
    SRC_D0,
    SRC_D1,
    SRC_D2,
    SRC_D3,
    SRC_D4,
    SRC_D5,
    SRC_D6,
    SRC_DOT,
    SRC_COLON,
    SRC_NONE
  } src_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

  typedef struct packed {
    fmt_t                            fmt;
    logic [NUM_DIGITS-1:0][3:0]      digits;
  } frame_rec_t;

  // Multiples zero to nine of the divisor of each decimal place.
  localparam logic [MULT_W-1:0] DIV_MULT [NUM_DIV_DIGITS][10] = '{
    '{23'd0, 23'd600000, 23'd1200000, 23'd1800000, 23'd2400000,
      23'd3000000, 23'd3600000, 23'd4200000, 23'd4800000, 23'd5400000},
    '{23'd0, 23'd60000, 23'd120000, 23'd180000, 23'd240000,
      23'd300000, 23'd360000, 23'd420000, 23'd480000, 23'd540000},
    '{23'd0, 23'd10000, 23'd20000, 23'd30000, 23'd40000,
      23'd50000, 23'd60000, 23'd70000, 23'd80000, 23'd90000},
    '{23'd0, 23'd1000, 23'd2000, 23'd3000, 23'd4000,
      23'd5000, 23'd6000, 23'd7000, 23'd8000, 23'd9000},
    '{23'd0, 23'd100, 23'd200, 23'd300, 23'd400,
      23'd500, 23'd600, 23'd700, 23'd800, 23'd900},
    '{23'd0, 23'd10, 23'd20, 23'd30, 23'd40,
      23'd50, 23'd60, 23'd70, 23'd80, 23'd90}
  };

  localparam src_t SRC_TAB [4][NUM_SYMS] = '{
    '{SRC_D2, SRC_D3, SRC_DOT, SRC_D4, SRC_D5, SRC_D6, SRC_NONE},
    '{SRC_D1, SRC_COLON, SRC_D2, SRC_D3, SRC_DOT, SRC_D4, SRC_D5},
    '{SRC_D0, SRC_D1, SRC_COLON, SRC_D2, SRC_D3, SRC_DOT, SRC_D4},
    '{SRC_NONE, SRC_NONE, SRC_NONE, SRC_NONE, SRC_NONE, SRC_NONE, SRC_NONE}
  };
  localparam logic [2:0] WID_TAB [4][NUM_SYMS] = '{
    '{3'd5, 3'd5, 3'd2, 3'd5, 3'd5, 3'd5, 3'd0},
    '{3'd4, 3'd1, 3'd5, 3'd5, 3'd1, 3'd5, 3'd5},
    '{3'd4, 3'd4, 3'd2, 3'd5, 3'd5, 3'd2, 3'd4},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  localparam logic [7:0] FONT_W4 [10][4] = '{
    '{8'h7E, 8'h81, 8'h81, 8'h7E}, '{8'h84, 8'h82, 8'hFF, 8'h80},
    '{8'hC6, 8'hA1, 8'h91, 8'h8E}, '{8'h42, 8'h89, 8'h89, 8'h76},
    '{8'h38, 8'h24, 8'h22, 8'hFF}, '{8'h5F, 8'h89, 8'h89, 8'h71},
    '{8'h7E, 8'h89, 8'h89, 8'h72}, '{8'h01, 8'hF1, 8'h09, 8'h07},
    '{8'h76, 8'h89, 8'h89, 8'h76}, '{8'h4E, 8'h91, 8'h91, 8'h7E}
  };
  localparam logic [7:0] FONT_W5 [10][5] = '{
    '{8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E}, '{8'h84, 8'h82, 8'hFF, 8'h80, 8'h80},
    '{8'hC6, 8'hA1, 8'h91, 8'h89, 8'h86}, '{8'h42, 8'h89, 8'h89, 8'h89, 8'h76},
    '{8'h38, 8'h24, 8'h22, 8'h21, 8'hFF}, '{8'h5F, 8'h89, 8'h89, 8'h89, 8'h71},
    '{8'h7E, 8'h89, 8'h89, 8'h89, 8'h72}, '{8'h01, 8'hF1, 8'h09, 8'h05, 8'h03},
    '{8'h76, 8'h89, 8'h89, 8'h89, 8'h76}, '{8'h4E, 8'h91, 8'h91, 8'h91, 8'h7E}
  };

  function automatic fmt_t classify(input logic [31:0] t);
    fmt_t f;
    if (t < LIMIT_SEC) begin
      f = FMT_SEC;
    end else if (t < LIMIT_MIN1) begin
      f = FMT_MIN1;
    end else if (t < LIMIT_HOUR) begin
      f = FMT_MIN2;
    end else begin
      f = FMT_OVER;
    end
    return f;
  endfunction

  function automatic logic [7:0] glyph(input src_t src, input logic [3:0] d,
                                       input logic [2:0] w, input logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    unique case (src)
      SRC_DOT: begin
        b = (w == 3'd2) ? 8'hC0 : 8'h80;
      end
      SRC_COLON: begin
        b = (w == 3'd2) ? 8'h66 : 8'h24;
      end
      SRC_NONE: begin
        b = 8'h00;
      end
      default: begin
        if (d > 4'd9) begin
          b = 8'h00;
        end else if (w == 3'd4) begin
          b = FONT_W4[d][k[1:0]];
        end else begin
          b = FONT_W5[d][(k > 3'd4) ? 3'd4 : k];
        end
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] column_byte(input frame_rec_t rec, input logic [4:0] col);
    logic [5:0] start;
    logic [5:0] stop;
    logic [2:0] w;
    logic [2:0] k;
    src_t       src;
    logic [3:0] d;
    logic [7:0] b;
    start = 6'd0;
    b     = 8'h00;
    for (int i = 0; i < NUM_SYMS; i++) begin
      w    = WID_TAB[rec.fmt][i];
      src  = SRC_TAB[rec.fmt][i];
      stop = start + {3'd0, w};
      k    = 3'({1'b0, col} - start);
      d    = (src <= SRC_D6) ? rec.digits[3'(src)] : 4'd0;
      if (({1'b0, col} >= start) && ({1'b0, col} < stop)) begin
        b = glyph(src, d, w, k);
      end
      start = stop + 6'd1;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/swcol_front.sv
// ---------------------------------------------------------------------------
// Stopwatch LED column front end
// Takes time beats, picks the display format and splits the time into
// decimal digits with a one-digit-per-cycle constant divider.
// ---------------------------------------------------------------------------
`default_nettype none

module swcol_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           time_ms,
  output logic                  enq,
  output swcol_pkg::frame_rec_t enq_rec,
  input  logic                  q_full
);
  import swcol_pkg::*;

  logic                       in_full;
  logic [31:0]                in_time;
  div_state_t                 state;
  div_state_t                 state_next;
  logic [REM_W-1:0]           rem;
  logic [2:0]                 dsel;
  logic [NUM_DIGITS-1:0][3:0] digits;
  fmt_t                       fmt;

  logic                       load;
  logic                       step;
  logic                       last_step;
  logic [3:0]                 qdig;
  logic [MULT_W-1:0]          qsub;
  logic [REM_W-1:0]           rem_next;

  assign full      = in_full;
  assign rem_next  = rem - qsub[REM_W-1:0];
  assign last_step = dsel == 3'(NUM_DIV_DIGITS - 1);
  assign enq_rec   = '{fmt: fmt, digits: digits};

  always_comb begin
    qdig = 4'd0;
    qsub = '0;
    for (int q = 1; q < 10; q++) begin
      if ({1'b0, rem} >= DIV_MULT[dsel][q]) begin
        qdig = 4'(q);
        qsub = DIV_MULT[dsel][q];
      end
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    step       = 1'b0;
    enq        = 1'b0;
    unique case (state)
      DIV_IDLE: begin
        if (in_full) begin
          load       = 1'b1;
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        step = 1'b1;
        if (last_step) begin
          state_next = DIV_HOLD;
        end
      end
      DIV_HOLD: begin
        if (!q_full) begin
          enq        = 1'b1;
          state_next = DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= DIV_IDLE;
      in_full <= 1'b0;
    end else begin
      state <= state_next;
      if (push && !in_full) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !in_full) begin
      in_time <= time_ms;
    end
    if (load) begin
      rem    <= in_time[REM_W-1:0];
      fmt    <= classify(in_time);
      digits <= '0;
      dsel   <= 3'd0;
    end else if (step) begin
      rem          <= rem_next;
      digits[dsel] <= qdig;
      if (last_step) begin
        digits[NUM_DIGITS-1] <= rem_next[3:0];
      end else begin
        dsel <= dsel + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swcol_queue.sv
// ---------------------------------------------------------------------------
// Stopwatch LED column frame queue
// Two-entry queue of digit records between the front end and the renderer.
// ---------------------------------------------------------------------------
`default_nettype none

module swcol_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  swcol_pkg::frame_rec_t wr_rec,
  output logic                  q_full,
  input  logic                  rd,
  output swcol_pkg::frame_rec_t rd_rec,
  output logic                  q_valid
);
  import swcol_pkg::*;

  frame_rec_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign rd_rec  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr && !q_full, rd && q_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      entry[wr_ptr] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swcol_back.sv
// ---------------------------------------------------------------------------
// Stopwatch LED column renderer
// Walks the display columns of one frame, looks up each column byte from
// the font tables and holds it in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module swcol_back #(
  parameter int DISPLAY_MODULES = swcol_pkg::DISPLAY_MODULES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  swcol_pkg::frame_rec_t q_rec,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [4:0]            column_index,
  output logic [7:0]            column_bits,
  output logic                  last_column,
  output logic                  over_hour
);
  import swcol_pkg::*;

  localparam int FRAME_COLS = (DISPLAY_MODULES * 8 > MAX_COLS) ? MAX_COLS
                                                               : DISPLAY_MODULES * 8;
  localparam logic [4:0] LAST_COL = 5'(FRAME_COLS - 1);

  logic [4:0] col;
  logic       out_valid;
  logic       advance;
  logic       at_last;

  assign empty   = !out_valid;
  assign advance = q_valid && (!out_valid || pop);
  assign at_last = col == LAST_COL;
  assign q_pop   = advance && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        col       <= at_last ? 5'd0 : col + 5'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      column_index <= col;
      column_bits  <= column_byte(q_rec, col);
      last_column  <= at_last;
      over_hour    <= q_rec.fmt == FMT_OVER;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/stopwatch_time_to_led_columns.sv
// ---------------------------------------------------------------------------
// Stopwatch time to LED matrix columns
// Renders an elapsed time in milliseconds as one frame of LED column bytes.
// ---------------------------------------------------------------------------
// Input channel: push/full with time_ms. A beat is taken while full is low;
// a one-entry input register lets the next time arrive while the previous
// one is still being split into digits.
// Output channel: empty/pop. Each frame is a run of min(8 * DISPLAY_MODULES,
// 32) beats carrying column_index, column_bits, last_column and over_hour;
// last_column marks the final column of the frame.
// With the renderer idle, a taken time beat passes the input register, the
// six digit steps of the constant divider in the front end, the frame queue
// and the output register before the first column of its frame is on the
// outputs. The renderer walks the columns, one column per cycle while the
// receiver pops; the divider finishes one time before it loads the next.
// Times of one hour or more give a blank frame with over_hour set.
// Reset empties the input register, the frame queue and the output register.
// When the receiver stops popping, the output register holds its column,
// the frame queue fills, and full rises once the input register is occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module stopwatch_time_to_led_columns #(
  parameter int DISPLAY_MODULES = swcol_pkg::DISPLAY_MODULES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] time_ms,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  column_index,
  output logic [7:0]  column_bits,
  output logic        last_column,
  output logic        over_hour
);
  import swcol_pkg::*;

  logic       enq;
  frame_rec_t enq_rec;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  frame_rec_t q_rec;

  swcol_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .time_ms (time_ms),
    .enq     (enq),
    .enq_rec (enq_rec),
    .q_full  (q_full)
  );

  swcol_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (enq),
    .wr_rec  (enq_rec),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_rec  (q_rec),
    .q_valid (q_valid)
  );

  swcol_back #(
    .DISPLAY_MODULES (DISPLAY_MODULES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .column_index (column_index),
    .column_bits  (column_bits),
    .last_column  (last_column),
    .over_hour    (over_hour)
  );

endmodule

`default_nettype wire

### test/stopwatch_time_to_led_columns_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Stopwatch time to LED columns testbench
// Feeds elapsed times through the push/full port and checks every column
// beat on the empty/pop port against a frame renderer kept in the bench.
// A directed table covers the range edges and the past-the-hour frames,
// then random times follow; both sides idle at random but for a steady run.
// ---------------------------------------------------------------------------
`default_nettype none

module stopwatch_time_to_led_columns_tb;

  localparam int DISPLAY_MODULES = 4;
  localparam int FRAME_COLS      = (DISPLAY_MODULES * 8 > 32) ? 32 : DISPLAY_MODULES * 8;
  localparam int RANDOM_TIMES    = 208;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDLE_PERCENT    = 22;

  localparam logic [31:0] MINUTE_MS  = 32'd60000;
  localparam logic [31:0] TEN_MIN_MS = 32'd600000;
  localparam logic [31:0] HOUR_MS    = 32'd3600000;

  localparam int GLYPH_POINT = 10;
  localparam int GLYPH_COLON = 11;

  typedef struct packed {
    logic [4:0] index;
    logic [7:0] bits;
    logic       last;
    logic       over;
  } column_beat_t;

  typedef struct packed {
    logic [31:0] t;
    logic        blank_over;
  } time_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] time_ms;
  logic        empty;
  logic        pop;
  logic [4:0]  column_index;
  logic [7:0]  column_bits;
  logic        last_column;
  logic        over_hour;

  column_beat_t pending_columns [$];
  int           mismatches;
  int           times_sent;
  int           columns_checked;
  int           hour_frames;
  int           stall_cycles;
  logic         steady_run;

  time_row_t directed_times [22] = '{
    '{32'd0, 1'b0},          '{32'd1, 1'b0},          '{32'd1000, 1'b0},
    '{32'd1234, 1'b0},       '{32'd9876, 1'b0},       '{32'd10203, 1'b0},
    '{32'd59990, 1'b0},      '{32'd59999, 1'b0},      '{32'd60000, 1'b0},
    '{32'd60009, 1'b0},      '{32'd69999, 1'b0},      '{32'd123456, 1'b0},
    '{32'd599999, 1'b0},     '{32'd600000, 1'b0},     '{32'd600099, 1'b0},
    '{32'd754321, 1'b0},     '{32'd3599999, 1'b0},    '{32'd3600000, 1'b1},
    '{32'd3600001, 1'b1},    '{32'h7FFFFFFF, 1'b1},   '{32'h80000000, 1'b1},
    '{32'hFFFFFFFF, 1'b1}
  };

  stopwatch_time_to_led_columns #(
    .DISPLAY_MODULES(DISPLAY_MODULES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .time_ms(time_ms),
    .empty(empty),
    .pop(pop),
    .column_index(column_index),
    .column_bits(column_bits),
    .last_column(last_column),
    .over_hour(over_hour)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [7:0] glyph_column(input int sym, input int wid, input int k);
    logic [31:0] narrow;
    logic [39:0] wide;
    logic [7:0]  b;
    case (sym)
      0: begin
        narrow = {8'h7E, 8'h81, 8'h81, 8'h7E};
        wide   = {8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E};
      end
      1: begin
        narrow = {8'h84, 8'h82, 8'hFF, 8'h80};
        wide   = {8'h84, 8'h82, 8'hFF, 8'h80, 8'h80};
      end
      2: begin
        narrow = {8'hC6, 8'hA1, 8'h91, 8'h8E};
        wide   = {8'hC6, 8'hA1, 8'h91, 8'h89, 8'h86};
      end
      3: begin
        narrow = {8'h42, 8'h89, 8'h89, 8'h76};
        wide   = {8'h42, 8'h89, 8'h89, 8'h89, 8'h76};
      end
      4: begin
        narrow = {8'h38, 8'h24, 8'h22, 8'hFF};
        wide   = {8'h38, 8'h24, 8'h22, 8'h21, 8'hFF};
      end
      5: begin
        narrow = {8'h5F, 8'h89, 8'h89, 8'h71};
        wide   = {8'h5F, 8'h89, 8'h89, 8'h89, 8'h71};
      end
      6: begin
        narrow = {8'h7E, 8'h89, 8'h89, 8'h72};
        wide   = {8'h7E, 8'h89, 8'h89, 8'h89, 8'h72};
      end
      7: begin
        narrow = {8'h01, 8'hF1, 8'h09, 8'h07};
        wide   = {8'h01, 8'hF1, 8'h09, 8'h05, 8'h03};
      end
      8: begin
        narrow = {8'h76, 8'h89, 8'h89, 8'h76};
        wide   = {8'h76, 8'h89, 8'h89, 8'h89, 8'h76};
      end
      9: begin
        narrow = {8'h4E, 8'h91, 8'h91, 8'h7E};
        wide   = {8'h4E, 8'h91, 8'h91, 8'h91, 8'h7E};
      end
      default: begin
        narrow = '0;
        wide   = '0;
      end
    endcase
    if (sym == GLYPH_POINT) begin
      b = (wid == 2) ? 8'hC0 : 8'h80;
    end else if (sym == GLYPH_COLON) begin
      b = (wid == 2) ? 8'h66 : 8'h24;
    end else if (wid == 4) begin
      b = narrow[31 - 8 * k -: 8];
    end else begin
      b = wide[39 - 8 * k -: 8];
    end
    return b;
  endfunction

  // Renders one time into a frame and queues its column beats.
  function automatic void predict_frame(input logic [31:0] t);
    int           sym [7];
    int           wid [7];
    int           n;
    int           pos;
    int unsigned  m;
    int unsigned  s;
    int unsigned  frac;
    logic [7:0]   cols [FRAME_COLS];
    logic         over;
    column_beat_t beat;
    for (int i = 0; i < FRAME_COLS; i++) begin
      cols[i] = 8'h00;
    end
    n    = 0;
    pos  = 0;
    over = 1'b0;
    if (t < MINUTE_MS) begin
      s    = t / 1000;
      frac = t % 1000;
      sym  = '{s / 10, s % 10, GLYPH_POINT, frac / 100, (frac / 10) % 10, frac % 10, 0};
      wid  = '{5, 5, 2, 5, 5, 5, 0};
      n    = 6;
    end else if (t < TEN_MIN_MS) begin
      m    = t / 60000;
      s    = (t % 60000) / 1000;
      frac = (t % 1000) / 10;
      sym  = '{m, GLYPH_COLON, s / 10, s % 10, GLYPH_POINT, frac / 10, frac % 10};
      wid  = '{4, 1, 5, 5, 1, 5, 5};
      n    = 7;
    end else if (t < HOUR_MS) begin
      m    = t / 60000;
      s    = (t % 60000) / 1000;
      frac = (t % 1000) / 100;
      sym  = '{m / 10, m % 10, GLYPH_COLON, s / 10, s % 10, GLYPH_POINT, frac};
      wid  = '{4, 4, 2, 5, 5, 2, 4};
      n    = 7;
    end else begin
      over = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < wid[i]; k++) begin
        if (pos < FRAME_COLS) begin
          cols[pos] = glyph_column(sym[i], wid[i], k);
        end
        pos++;
      end
      if (i + 1 < n) begin
        pos++;
      end
    end
    for (int i = 0; i < FRAME_COLS; i++) begin
      beat.index = 5'(i);
      beat.bits  = cols[i];
      beat.last  = (i == FRAME_COLS - 1);
      beat.over  = over;
      pending_columns.push_back(beat);
    end
  endfunction

  function automatic logic [31:0] random_time();
    logic [31:0] t;
    case ($urandom_range(0, 10))
      0, 1, 2: begin
        t = $urandom_range(0, 59999);
      end
      3, 4, 5: begin
        t = $urandom_range(60000, 599999);
      end
      6, 7, 8: begin
        t = $urandom_range(600000, 3599999);
      end
      9: begin
        t = $urandom;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: t = MINUTE_MS;
          1: t = TEN_MIN_MS;
          default: t = HOUR_MS;
        endcase
        t = t + $urandom_range(0, 4) - 2;
      end
    endcase
    return t;
  endfunction

  task automatic send_time(input logic [31:0] t, input logic blank_over);
    column_beat_t beat;
    @(negedge clk);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    time_ms <= t;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    times_sent++;
    if (t >= HOUR_MS) begin
      hour_frames++;
    end
    if (blank_over) begin
      for (int i = 0; i < FRAME_COLS; i++) begin
        beat.index = 5'(i);
        beat.bits  = 8'h00;
        beat.last  = (i == FRAME_COLS - 1);
        beat.over  = 1'b1;
        pending_columns.push_back(beat);
      end
    end else begin
      predict_frame(t);
    end
  endtask

  initial begin
    column_beat_t exp_beat;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      pop <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
      @(posedge clk);
      if (pop && !empty) begin
        columns_checked++;
        if (pending_columns.size() == 0) begin
          $error("column beat %0d arrived with no frame pending", column_index);
          mismatches++;
        end else begin
          exp_beat = pending_columns.pop_front();
          if (column_index !== exp_beat.index) begin
            $error("column_index: expected %0d, got %0d", exp_beat.index, column_index);
            mismatches++;
          end
          if (column_bits !== exp_beat.bits) begin
            $error("column_bits: expected %02h, got %02h", exp_beat.bits, column_bits);
            mismatches++;
          end
          if (last_column !== exp_beat.last) begin
            $error("last_column: expected %0b, got %0b", exp_beat.last, last_column);
            mismatches++;
          end
          if (over_hour !== exp_beat.over) begin
            $error("over_hour: expected %0b, got %0b", exp_beat.over, over_hour);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (rst === 1'b0);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("Timed out after %0d cycles without a beat.", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    push            = 1'b0;
    pop             = 1'b0;
    time_ms         = '0;
    steady_run      = 1'b0;
    mismatches      = 0;
    times_sent      = 0;
    columns_checked = 0;
    hour_frames     = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_times[i]) begin
      send_time(directed_times[i].t, directed_times[i].blank_over);
    end

    for (int i = 0; i < RANDOM_TIMES; i++) begin
      steady_run = (i >= 100) && (i < 140);
      send_time(random_time(), 1'b0);
    end
    steady_run = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    while (pending_columns.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d times (%0d directed, %0d past the hour), checked %0d column beats.",
             times_sent, $size(directed_times), hour_frames, columns_checked);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
